@@ hw/rtl/sbg_pkg.sv @@
// ----------------------------------------------------------------------------
// sbg_pkg
// Shared types, constant tables and the LPS round function of the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sbg_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [4:0] LPS_STEPS = 5'd25;

  // One queued request: a message word, its byte count and the final flag.
  // A final word is already padded with the 0x01 byte.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nb;
    logic        fin;
  } sbg_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  // Row 0 is selected by the most significant bit of a word.
  localparam logic [63:0] LMAT [64] = '{
    64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
    64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
    64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
    64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
    64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
    64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
    64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
    64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
    64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
    64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
    64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
    64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
    64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
    64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
  };

  // Round constants, word 0 least significant.
  localparam logic [63:0] RCON [12][8] = '{
    '{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
      64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
    '{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
      64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
    '{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
      64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
    '{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
      64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
    '{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
      64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
    '{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
      64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
    '{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
      64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
    '{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
      64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
    '{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
      64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
    '{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
      64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720},
    '{64'h1b2df381cda4ca6b,64'h5dd86fc04a59a2de,64'h986e477d1dcdbaef,64'hcab948eaef711d8a,
      64'h7966841421800120,64'h6107abebbb6bfad8,64'h94fe5a63cdc60230,64'hfb89c8efd09ecd7b},
    '{64'h20d71bf14a92bc48,64'h991bb2d9d517f4fa,64'h5228e188aaa41de7,64'h86cc91189def805d,
      64'h9b9f2130d41220f8,64'h771ddfbc323ca4cd,64'h7ab14904b08013d2,64'hba3116f167e78e37}
  };

  // S-box, byte transposition and linear map over a 512-bit state.
  function automatic logic [511:0] lps(input logic [511:0] x);
    logic [511:0] r;
    logic [7:0]   v;
    r = '0;
    for (int w = 0; w < 8; w++) begin
      for (int j = 0; j < 8; j++) begin
        v = SBOX[x[64*j + 8*w +: 8]];
        for (int b = 0; b < 8; b++) begin
          if (v[b]) begin
            r[64*w +: 64] = r[64*w +: 64] ^ LMAT[63 - 8*j - b];
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [511:0] rcon_row(input logic [3:0] idx);
    logic [511:0] r;
    logic [3:0]   i;
    i = (idx < 4'd12) ? idx : 4'd0;
    for (int w = 0; w < 8; w++) begin
      r[64*w +: 64] = RCON[i][w];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sbg_front.sv @@
// ----------------------------------------------------------------------------
// sbg_front
// Accepts message words, clips the byte count and pads the final word.
// ----------------------------------------------------------------------------
`default_nettype none

module sbg_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [63:0]       msg_word,
  input  wire logic [3:0]        word_bytes,
  input  wire logic              last_word,
  output logic                   push_valid,
  output sbg_pkg::sbg_item_t     push_item,
  input  wire logic              push_ready
);
  import sbg_pkg::*;

  logic       pend;
  logic [3:0] nbc;
  logic [63:0] padded;

  assign nbc = (word_bytes > 4'd8) ? 4'd8 : word_bytes;

  always_comb begin
    padded = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbc) begin
        padded[8*i +: 8] = msg_word[8*i +: 8];
      end
    end
    if (nbc < 4'd8) begin
      padded[8*nbc[2:0] +: 8] = 8'h01;
    end
  end

  assign in_ready   = push_ready && !pend;
  assign push_valid = pend || in_valid;

  always_comb begin
    if (pend) begin
      // A final word with eight bytes is followed by a block holding only padding.
      push_item = '{word: 64'h1, nb: 4'd0, fin: 1'b1};
    end else if (last_word && nbc < 4'd8) begin
      push_item = '{word: padded, nb: nbc, fin: 1'b1};
    end else begin
      push_item = '{word: msg_word, nb: 4'd8, fin: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (pend) begin
      if (push_ready) begin
        pend <= 1'b0;
      end
    end else if (in_valid && in_ready && last_word && nbc == 4'd8) begin
      pend <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sbg_queue.sv @@
// ----------------------------------------------------------------------------
// sbg_queue
// Short request queue between the front and the compression back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbg_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire sbg_pkg::sbg_item_t push_item,
  output logic                   push_ready,
  output logic                   pop_valid,
  output sbg_pkg::sbg_item_t     pop_item,
  input  wire logic              pop_ready
);
  import sbg_pkg::*;

  sbg_item_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sbg_back.sv @@
// ----------------------------------------------------------------------------
// sbg_back
// Block assembly, compression with one shared LPS unit, and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sbg_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  input  wire sbg_pkg::sbg_item_t pop_item,
  output logic                   pop_ready,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            digest_word,
  output logic                   digest_last
);
  import sbg_pkg::*;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [1:0] K_BLOCK = 2'd0;
  localparam logic [1:0] K_LAST  = 2'd1;
  localparam logic [1:0] K_FN    = 2'd2;
  localparam logic [1:0] K_FS    = 2'd3;

  logic [1:0]   state;
  logic [1:0]   kind;
  logic         mode;
  logic [511:0] h, n, sg, m, st, k;
  logic [511:0] m_next;
  logic [2:0]   widx;
  logic [2:0]   oidx;
  logic [4:0]   step;
  logic [9:0]   delta;
  logic         cn, cs;
  logic [511:0] lps_in, lps_out;
  logic [3:0]   rnd;
  logic [2:0]   aidx;
  logic         add_en;
  logic [64:0]  nsum, ssum;
  logic [63:0]  nadd;

  assign pop_ready   = state == ST_FILL;
  assign out_valid   = state == ST_OUT;
  assign digest_word = h[64*oidx +: 64];
  assign digest_last = oidx == 3'd7;

  always_comb begin
    m_next = m;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) == widx) begin
        m_next[64*i +: 64] = pop_item.word;
      end else if (pop_item.fin && 3'(i) > widx) begin
        m_next[64*i +: 64] = '0;
      end
    end
  end

  // Step 0 derives the first key; odd steps update the state, even steps the key, up to the feed-forward.
  assign rnd = step[4:1] - 4'd1;
  always_comb begin
    if (step == 5'd0) begin
      lps_in = (kind == K_FN || kind == K_FS) ? h : (h ^ n);
    end else if (step[0]) begin
      lps_in = st ^ k;
    end else begin
      lps_in = k ^ rcon_row(rnd);
    end
  end
  assign lps_out = lps(lps_in);

  // The counter and checksum are added one word per cycle during the rounds of a message block.
  assign aidx   = 3'(step - 5'd1);
  assign add_en = (kind == K_BLOCK || kind == K_LAST) && step >= 5'd1 && step <= 5'd8;
  assign nadd   = (aidx == 3'd0) ? {54'd0, delta} : 64'd0;
  assign nsum   = {1'b0, n[64*aidx +: 64]} + {1'b0, nadd} + {64'd0, cn};
  assign ssum   = {1'b0, sg[64*aidx +: 64]} + {1'b0, m[64*aidx +: 64]} + {64'd0, cs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      kind  <= K_BLOCK;
      mode  <= 1'b0;
      h     <= '0;
      n     <= '0;
      sg    <= '0;
      widx  <= '0;
      oidx  <= '0;
      step  <= '0;
      cn    <= 1'b0;
      cs    <= 1'b0;
    end else if (cfg_valid) begin
      mode  <= cfg_data;
      h     <= cfg_data ? {64{8'h01}} : '0;
      n     <= '0;
      sg    <= '0;
      widx  <= '0;
      state <= ST_FILL;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (pop_valid) begin
            m    <= m_next;
            step <= '0;
            if (!pop_item.fin) begin
              if (widx == 3'd7) begin
                widx  <= '0;
                kind  <= K_BLOCK;
                delta <= 10'd512;
                state <= ST_COMP;
              end else begin
                widx <= widx + 3'd1;
              end
            end else begin
              widx  <= '0;
              kind  <= K_LAST;
              delta <= {1'b0, widx, 6'd0} + {4'd0, pop_item.nb[2:0], 3'd0};
              state <= ST_COMP;
            end
          end
        end
        ST_COMP: begin
          if (step == 5'd0) begin
            st <= m;
            k  <= lps_out;
            cn <= 1'b0;
            cs <= 1'b0;
          end else if (step < LPS_STEPS) begin
            if (step[0]) begin
              st <= lps_out;
            end else begin
              k <= lps_out;
            end
          end
          if (add_en) begin
            n[64*aidx +: 64]  <= nsum[63:0];
            cn                <= nsum[64];
            sg[64*aidx +: 64] <= ssum[63:0];
            cs                <= ssum[64];
          end
          if (step == LPS_STEPS) begin
            h    <= h ^ st ^ k ^ m;
            step <= '0;
            unique case (kind)
              K_BLOCK: state <= ST_FILL;
              K_LAST: begin
                kind <= K_FN;
                m    <= n;
              end
              K_FN: begin
                kind <= K_FS;
                m    <= sg;
              end
              K_FS: begin
                state <= ST_OUT;
                oidx  <= mode ? 3'd4 : 3'd0;
              end
            endcase
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (oidx == 3'd7) begin
              h     <= mode ? {64{8'h01}} : '0;
              n     <= '0;
              sg    <= '0;
              widx  <= '0;
              state <= ST_FILL;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/streebog_hash_engine_top.sv @@
// ----------------------------------------------------------------------------
// streebog_hash_engine_top
// Streebog hash engine with a 512-bit or 256-bit digest.
// ----------------------------------------------------------------------------
// Message words enter on the in channel, first byte least significant; the
// final word is flagged and carries its valid byte count. A front stage pads
// the final word and places requests in a four-entry queue, so input keeps
// flowing while the back end compresses. The back end collects eight words,
// then runs one compression through a single shared LPS unit
// (one key derivation, twelve rounds of state and key, one feed-forward).
// After the final word, the padded block and the two closing compressions
// run, then the digest words appear on the out channel, eight in 512-bit
// mode or four in 256-bit mode, the last one flagged. If the receiver
// stalls, the digest word holds and the queue fills, after which in_ready
// drops. A configuration write selects the mode and restarts the hash
// state; it is meant for an idle engine. Reset selects 512-bit mode,
// empties the queue and clears the hash and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module streebog_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] msg_word,
  input  wire logic [3:0]  word_bytes,
  input  wire logic        last_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest_word,
  output logic             digest_last
);
  import sbg_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  sbg_item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  sbg_front u_front (
    .clk, .rst, .in_valid, .in_ready, .msg_word, .word_bytes, .last_word,
    .push_valid, .push_item, .push_ready
  );

  sbg_queue u_queue (
    .clk, .rst, .push_valid, .push_item, .push_ready,
    .pop_valid, .pop_item, .pop_ready
  );

  sbg_back u_back (
    .clk, .rst, .pop_valid, .pop_item, .pop_ready,
    .cfg_valid, .cfg_data, .out_valid, .out_ready, .digest_word, .digest_last
  );

endmodule

`default_nettype wire
